FILE: design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, types and helpers of the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  // pool geometry (both values are powers of two)
  localparam int unsigned MIN_BLOCK_BYTES = 16;
  localparam int unsigned BLOCK_COUNT     = 1024;

  localparam int unsigned LOG_MIN    = $clog2(MIN_BLOCK_BYTES);
  localparam int unsigned LOG_BLOCKS = $clog2(BLOCK_COUNT);
  localparam int unsigned RAM_DEPTH  = 2 * BLOCK_COUNT;
  localparam int unsigned ADDR_W     = LOG_BLOCKS + 1;
  localparam int unsigned HEAP_W     = LOG_BLOCKS + 2;
  localparam int unsigned LEV_W      = $clog2(LOG_BLOCKS + 2);
  localparam int unsigned LG_W       = 6;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [HEAP_W-1:0]     heap_t;
  typedef logic [LEV_W-1:0]      lev_t;
  typedef logic [LOG_BLOCKS-1:0] blk_t;
  typedef logic [LG_W-1:0]       lg_t;

  typedef enum logic [1:0] {
    NODE_EMPTY   = 2'd0,
    NODE_DIVIDED = 2'd1,
    NODE_BUSY    = 2'd2
  } node_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADADDR = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_SRD, S_SEV, S_DECIDE,
    S_MARK, S_FDRD, S_FDEV, S_MRD, S_MEV, S_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_CLEAR, OP_LOAD, OP_SRD, OP_SEV, OP_MSTART, OP_MARK,
    OP_FDRD, OP_FDEV, OP_MRD, OP_MEV, OP_NOMEM, OP_BADADDR, OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mode_free;
    logic too_large;
    logic bad_addr;
    logic srch_done;
    logic found;
    logic mark_last;
    logic fd_stop;
    logic at_root;
    logic merge_last;
    logic out_free;
  } dp_stat_t;

  // ceiling of log2 of a byte count, zero for counts of zero and one
  function automatic lg_t ceil_log2_32(input logic [31:0] v);
    logic [31:0] x;
    lg_t         r;
    x = v - 32'd1;
    r = '0;
    if (v > 32'd1) begin
      for (int i = 0; i < 32; i++) begin
        if (x[i]) r = lg_t'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/bba_req_if.sv
// ----------------------------------------------------------------------------
// bba_req_if
// Request channel: allocate or free, with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] request_bytes;
  logic [31:0] byte_offset;

  modport source (output valid, mode, request_bytes, byte_offset, input ready);
  modport sink   (input valid, mode, request_bytes, byte_offset, output ready);
endinterface

`default_nettype wire

FILE: design/bba_rsp_if.sv
// ----------------------------------------------------------------------------
// bba_rsp_if
// Result channel: granted offset and status, with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] granted_offset;
  logic [1:0]  status;

  modport source (output valid, granted_offset, status, input ready);
  modport sink   (input valid, granted_offset, status, output ready);
endinterface

`default_nettype wire

FILE: design/buddy_block_allocator.sv
// Allocate runs a depth-first best-fit search over the tree nodes, then
//   marks the tree levels from the target node up to the root.
// Free reads the nodes on the path down, then merges empty buddies up;
//   a too large request or a bad address goes straight to the result.
// One request at a time: a new request is taken only once the last result is pushed.
// Reset: a clearing pass writes all 2048 nodes empty first.
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Best-fit buddy allocator over a binary tree of node states.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bba_req_if.sink    in_ch,
  bba_rsp_if.source  out_ch
);

  bba_pkg::dp_cmd_t  cmd;
  bba_pkg::dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_mode            (in_ch.mode),
    .in_request_bytes   (in_ch.request_bytes),
    .in_byte_offset     (in_ch.byte_offset),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_granted_offset (out_ch.granted_offset),
    .out_status         (out_ch.status)
  );

endmodule

`default_nettype wire

FILE: design/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read first port, read data registered
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: design/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clearing pass, search, mark, release walk and merge walk.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t      cmd
);

  bba_pkg::ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bba_pkg::S_CLEAR;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.op    = bba_pkg::OP_IDLE;
    in_ready  = 1'b0;
    unique case (state_r)
      bba_pkg::S_CLEAR: begin
        cmd.op = bba_pkg::OP_CLEAR;
        if (stat.clear_last) state_nxt = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = bba_pkg::OP_LOAD;
          state_nxt = bba_pkg::S_DISPATCH;
        end
      end
      bba_pkg::S_DISPATCH: begin
        if (!stat.mode_free) begin
          if (stat.too_large) begin
            cmd.op    = bba_pkg::OP_NOMEM;
            state_nxt = bba_pkg::S_DONE;
          end else begin
            state_nxt = bba_pkg::S_SRD;
          end
        end else if (stat.bad_addr) begin
          cmd.op    = bba_pkg::OP_BADADDR;
          state_nxt = bba_pkg::S_DONE;
        end else begin
          state_nxt = bba_pkg::S_FDRD;
        end
      end
      bba_pkg::S_SRD: begin
        cmd.op    = bba_pkg::OP_SRD;
        state_nxt = bba_pkg::S_SEV;
      end
      bba_pkg::S_SEV: begin
        cmd.op    = bba_pkg::OP_SEV;
        state_nxt = stat.srch_done ? bba_pkg::S_DECIDE : bba_pkg::S_SRD;
      end
      bba_pkg::S_DECIDE: begin
        if (stat.found) begin
          cmd.op    = bba_pkg::OP_MSTART;
          state_nxt = bba_pkg::S_MARK;
        end else begin
          cmd.op    = bba_pkg::OP_NOMEM;
          state_nxt = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_MARK: begin
        cmd.op = bba_pkg::OP_MARK;
        if (stat.mark_last) state_nxt = bba_pkg::S_DONE;
      end
      bba_pkg::S_FDRD: begin
        cmd.op    = bba_pkg::OP_FDRD;
        state_nxt = bba_pkg::S_FDEV;
      end
      bba_pkg::S_FDEV: begin
        cmd.op = bba_pkg::OP_FDEV;
        if (stat.fd_stop) state_nxt = stat.at_root ? bba_pkg::S_DONE : bba_pkg::S_MRD;
        else              state_nxt = bba_pkg::S_FDRD;
      end
      bba_pkg::S_MRD: begin
        cmd.op    = bba_pkg::OP_MRD;
        state_nxt = bba_pkg::S_MEV;
      end
      bba_pkg::S_MEV: begin
        cmd.op    = bba_pkg::OP_MEV;
        state_nxt = stat.merge_last ? bba_pkg::S_DONE : bba_pkg::S_MRD;
      end
      bba_pkg::S_DONE: begin
        cmd.op = bba_pkg::OP_PUSH;
        if (stat.out_free) state_nxt = bba_pkg::S_IDLE;
      end
      default: state_nxt = bba_pkg::S_CLEAR;
    endcase
  end

  // an accepted request is dispatched next
  a_load_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == bba_pkg::S_DISPATCH)
    else $error("accepted request not dispatched");

  // search evaluation always follows its read
  a_sev_after_srd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bba_pkg::S_SEV |-> $past(state_r) == bba_pkg::S_SRD)
    else $error("search evaluate without read");

  // merge evaluation always follows its read
  a_mev_after_mrd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bba_pkg::S_MEV |-> $past(state_r) == bba_pkg::S_MRD)
    else $error("merge evaluate without read");

endmodule

`default_nettype wire

FILE: design/bba_dpath.sv
// ----------------------------------------------------------------------------
// bba_dpath
// Node-state memory, tree walk registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bba_pkg::dp_cmd_t  cmd,
  output bba_pkg::dp_stat_t      stat,
  input  wire logic              in_mode,
  input  wire logic [31:0]       in_request_bytes,
  input  wire logic [31:0]       in_byte_offset,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [31:0]            out_granted_offset,
  output logic [1:0]             out_status
);

  // walk registers
  logic                   mode_r, mode_nxt;
  logic                   too_large_r, too_large_nxt;
  logic                   bad_r, bad_nxt;
  bba_pkg::lev_t          tlev_r, tlev_nxt;
  bba_pkg::blk_t          pos_r, pos_nxt;
  bba_pkg::heap_t         h_r, h_nxt;
  bba_pkg::lev_t          d_r, d_nxt;
  logic                   best_v_r, best_v_nxt;
  bba_pkg::lev_t          best_lev_r, best_lev_nxt;
  bba_pkg::heap_t         best_h_r, best_h_nxt;
  logic                   first_r, first_nxt;
  logic                   flag_r, flag_nxt;
  logic [bba_pkg::LOG_BLOCKS:0] path_empty_r, path_empty_nxt;
  bba_pkg::addr_t         clr_cnt_r, clr_cnt_nxt;
  logic [31:0]            res_off_r, res_off_nxt;
  bba_pkg::status_t       res_st_r, res_st_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [31:0]            out_off_r, out_off_nxt;
  bba_pkg::status_t       out_st_r, out_st_nxt;

  // memory port
  logic                   ram_we;
  bba_pkg::addr_t         ram_addr;
  logic [1:0]             ram_wdata;
  logic [1:0]             ram_rdata;

  // helpers
  bba_pkg::lg_t           lg, wl;
  bba_pkg::heap_t         hn, h_skip, rel, at_w;
  bba_pkg::lev_t          tz;
  logic                   wrap;
  logic                   s_busy, s_empty;
  logic                   exact, cand, descend;
  logic                   leaf, merge;
  bba_pkg::blk_t          pos_sh;
  logic                   out_free;

  bba_ram #(.WIDTH(2), .DEPTH(bba_pkg::RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // next node in preorder after skipping the subtree at h_r
  always_comb begin
    hn = h_r + bba_pkg::heap_t'(1);
    tz = '0;
    for (int i = bba_pkg::HEAP_W - 1; i >= 0; i--) begin
      if (hn[i]) tz = bba_pkg::lev_t'(i);
    end
    wrap   = tz > d_r;
    h_skip = hn >> tz;
  end

  assign s_busy   = ram_rdata == bba_pkg::NODE_BUSY;
  assign s_empty  = ram_rdata == bba_pkg::NODE_EMPTY;
  assign exact    = !s_busy && (d_r == tlev_r) && s_empty;
  assign cand     = !s_busy && (d_r < tlev_r) && s_empty;
  assign descend  = !s_busy && (d_r < tlev_r) && !s_empty;
  assign leaf     = d_r == bba_pkg::lev_t'(bba_pkg::LOG_BLOCKS);
  assign merge    = flag_r && s_empty;
  assign pos_sh   = pos_r >> (bba_pkg::lev_t'(bba_pkg::LOG_BLOCKS - 1) - d_r);
  assign out_free = !out_valid_r || out_ready;

  // size rounding of an allocate request
  always_comb begin
    lg = bba_pkg::ceil_log2_32(in_request_bytes);
    wl = (lg > bba_pkg::lg_t'(bba_pkg::LOG_MIN)) ? lg - bba_pkg::lg_t'(bba_pkg::LOG_MIN) : '0;
  end

  // start block of the best node
  always_comb begin
    rel  = best_h_r ^ (bba_pkg::heap_t'(1) << best_lev_r);
    at_w = rel << (bba_pkg::lev_t'(bba_pkg::LOG_BLOCKS) - best_lev_r);
  end

  // command decode
  always_comb begin
    mode_nxt       = mode_r;
    too_large_nxt  = too_large_r;
    bad_nxt        = bad_r;
    tlev_nxt       = tlev_r;
    pos_nxt        = pos_r;
    h_nxt          = h_r;
    d_nxt          = d_r;
    best_v_nxt     = best_v_r;
    best_lev_nxt   = best_lev_r;
    best_h_nxt     = best_h_r;
    first_nxt      = first_r;
    flag_nxt       = flag_r;
    path_empty_nxt = path_empty_r;
    clr_cnt_nxt    = clr_cnt_r;
    res_off_nxt    = res_off_r;
    res_st_nxt     = res_st_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_off_nxt    = out_off_r;
    out_st_nxt     = out_st_r;
    ram_we         = 1'b0;
    ram_addr       = bba_pkg::addr_t'(h_r - bba_pkg::heap_t'(1));
    ram_wdata      = bba_pkg::NODE_EMPTY;
    stat           = '0;
    stat.clear_last = &clr_cnt_r;
    stat.mode_free  = mode_r == bba_pkg::MODE_FREE;
    stat.too_large  = too_large_r;
    stat.bad_addr   = bad_r;
    stat.found      = best_v_r;
    stat.mark_last  = h_r == bba_pkg::heap_t'(1);
    stat.at_root    = d_r == '0;
    stat.merge_last = d_r == bba_pkg::lev_t'(1);
    stat.out_free   = out_free;
    unique case (cmd.op)
      bba_pkg::OP_IDLE: begin
      end
      bba_pkg::OP_CLEAR: begin
        ram_we      = 1'b1;
        ram_addr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + bba_pkg::addr_t'(1);
      end
      bba_pkg::OP_LOAD: begin
        mode_nxt      = in_mode;
        too_large_nxt = wl > bba_pkg::lg_t'(bba_pkg::LOG_BLOCKS);
        tlev_nxt      = bba_pkg::lev_t'(bba_pkg::LOG_BLOCKS) - bba_pkg::lev_t'(wl);
        pos_nxt       = in_byte_offset[bba_pkg::LOG_MIN +: bba_pkg::LOG_BLOCKS];
        bad_nxt       = (in_byte_offset >> (bba_pkg::LOG_MIN + bba_pkg::LOG_BLOCKS)) != '0;
        h_nxt         = bba_pkg::heap_t'(1);
        d_nxt         = '0;
        best_v_nxt    = 1'b0;
        res_off_nxt   = '0;
        res_st_nxt    = bba_pkg::ST_OK;
      end
      bba_pkg::OP_SRD: begin
      end
      bba_pkg::OP_SEV: begin
        // busy or too small: skip; empty: candidate, or the result at the wanted level; divided: go down
        if (exact) begin
          best_v_nxt     = 1'b1;
          best_lev_nxt   = d_r;
          best_h_nxt     = h_r;
          stat.srch_done = 1'b1;
        end else if (descend) begin
          h_nxt = h_r << 1;
          d_nxt = d_r + bba_pkg::lev_t'(1);
        end else begin
          if (cand && (!best_v_r || d_r > best_lev_r)) begin
            best_v_nxt   = 1'b1;
            best_lev_nxt = d_r;
            best_h_nxt   = h_r;
          end
          stat.srch_done = wrap;
          h_nxt          = h_skip;
          d_nxt          = d_r - tz;
        end
      end
      bba_pkg::OP_MSTART: begin
        h_nxt       = best_h_r << (tlev_r - best_lev_r);
        first_nxt   = 1'b1;
        res_off_nxt = 32'(at_w[bba_pkg::LOG_BLOCKS-1:0]) << bba_pkg::LOG_MIN;
      end
      bba_pkg::OP_MARK: begin
        // target busy, ancestors divided
        ram_we    = 1'b1;
        ram_wdata = first_r ? bba_pkg::NODE_BUSY : bba_pkg::NODE_DIVIDED;
        h_nxt     = h_r >> 1;
        first_nxt = 1'b0;
      end
      bba_pkg::OP_FDRD: begin
      end
      bba_pkg::OP_FDEV: begin
        if (s_busy) begin
          ram_we       = 1'b1;
          flag_nxt     = 1'b1;
          stat.fd_stop = 1'b1;
        end else if (leaf) begin
          flag_nxt     = s_empty;
          stat.fd_stop = 1'b1;
        end else begin
          path_empty_nxt[d_r] = s_empty;
          h_nxt = {h_r[bba_pkg::HEAP_W-2:0], pos_sh[0]};
          d_nxt = d_r + bba_pkg::lev_t'(1);
        end
      end
      bba_pkg::OP_MRD: begin
        ram_addr = bba_pkg::addr_t'((h_r ^ bba_pkg::heap_t'(1)) - bba_pkg::heap_t'(1));
      end
      bba_pkg::OP_MEV: begin
        // parent empties when both children are empty
        ram_addr = bba_pkg::addr_t'((h_r >> 1) - bba_pkg::heap_t'(1));
        ram_we   = merge;
        flag_nxt = merge || path_empty_r[d_r - bba_pkg::lev_t'(1)];
        h_nxt    = h_r >> 1;
        d_nxt    = d_r - bba_pkg::lev_t'(1);
      end
      bba_pkg::OP_NOMEM: begin
        res_st_nxt = bba_pkg::ST_NOMEM;
      end
      bba_pkg::OP_BADADDR: begin
        res_st_nxt = bba_pkg::ST_BADADDR;
      end
      bba_pkg::OP_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = res_off_r;
          out_st_nxt    = res_st_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk and payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    too_large_r  <= too_large_nxt;
    bad_r        <= bad_nxt;
    tlev_r       <= tlev_nxt;
    pos_r        <= pos_nxt;
    h_r          <= h_nxt;
    d_r          <= d_nxt;
    best_v_r     <= best_v_nxt;
    best_lev_r   <= best_lev_nxt;
    best_h_r     <= best_h_nxt;
    first_r      <= first_nxt;
    flag_r       <= flag_nxt;
    path_empty_r <= path_empty_nxt;
    res_off_r    <= res_off_nxt;
    res_st_r     <= res_st_nxt;
    out_off_r    <= out_off_nxt;
    out_st_r     <= out_st_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_granted_offset = out_off_r;
  assign out_status         = out_st_r;

  // the search never writes the node store
  a_sev_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == bba_pkg::OP_SEV |-> !ram_we)
    else $error("node store written during search");

  // the search never goes below the wanted level
  a_sev_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == bba_pkg::OP_SEV |-> d_r <= tlev_r)
    else $error("search below target level");

  // a result appears only from a push
  a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.op == bba_pkg::OP_PUSH))
    else $error("result without push");

endmodule

`default_nettype wire

FILE: tb/buddy_block_allocator_test.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_test
// Self-checking bench for the buddy block allocator. It sends a short run of
// edge-case requests, then random allocate and free requests, and predicts
// each result from its own copy of the node tree. Both channels idle and
// stall at random, and the result side is held off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_test;

  localparam int unsigned NODE_COUNT = 2 * bba_pkg::BLOCK_COUNT;
  localparam int unsigned POOL_BYTES = bba_pkg::BLOCK_COUNT * bba_pkg::MIN_BLOCK_BYTES;
  localparam int unsigned STALL_LIMIT = 40000;
  localparam int unsigned RANDOM_BEATS = 630;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    logic        mode;
    logic [31:0] request_bytes;
    logic [31:0] byte_offset;
  } request_t;

  typedef struct {
    logic [31:0]      granted_offset;
    bba_pkg::status_t status;
  } grant_t;

  logic clk;
  logic rst_n;

  bba_req_if in_ch ();
  bba_rsp_if out_ch ();

  buddy_block_allocator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  request_t       pending_requests[$];
  grant_t         awaited_grants[$];
  bba_pkg::node_t tree[NODE_COUNT];
  int             error_count;
  int             accepted_count;
  int             quiet_cycles;
  int             hold_left;
  bit             hold_done;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // best-fit allocate or release with buddy merging on the shadow tree
  function automatic grant_t allocator_outcome(input request_t rq);
    grant_t          g;
    longint unsigned k, want, span, lo, best_span, best_lo, blk;
    int              i, lev, par, node, j;
    bit              found, walking;
    bit              reach[NODE_COUNT];
    int              trail[$];
    g.granted_offset = '0;
    g.status = bba_pkg::ST_OK;
    if (rq.mode == bba_pkg::MODE_ALLOC) begin
      k = 1;
      while (k < rq.request_bytes) k = k * 2;
      if (k < bba_pkg::MIN_BLOCK_BYTES) k = bba_pkg::MIN_BLOCK_BYTES;
      want = (k + bba_pkg::MIN_BLOCK_BYTES - 1) / bba_pkg::MIN_BLOCK_BYTES;
      // smallest empty node reachable through divided nodes, leftmost on ties
      found = 1'b0;
      best_span = 0;
      best_lo = 0;
      lev = 0;
      for (i = 0; i < NODE_COUNT - 1; i++) begin
        if (i + 1 >= (2 << lev)) lev++;
        span = bba_pkg::BLOCK_COUNT >> lev;
        lo = (i + 1 - (1 << lev)) * span;
        par = (i == 0) ? 0 : (i - 1) / 2;
        reach[i] = (i == 0) || (reach[par] && tree[par] == bba_pkg::NODE_DIVIDED);
        if (reach[i] && tree[i] == bba_pkg::NODE_EMPTY && span >= want &&
            (!found || span < best_span)) begin
          found = 1'b1;
          best_span = span;
          best_lo = lo;
        end
      end
      if (found) begin
        // split down to the wanted size
        node = 0;
        span = bba_pkg::BLOCK_COUNT;
        lo = 0;
        while (span > want) begin
          if (tree[node] == bba_pkg::NODE_EMPTY) tree[node] = bba_pkg::NODE_DIVIDED;
          span = span / 2;
          if (best_lo >= lo + span) begin
            node = 2 * node + 2;
            lo = lo + span;
          end else begin
            node = 2 * node + 1;
          end
        end
        tree[node] = bba_pkg::NODE_BUSY;
        g.granted_offset = 32'(best_lo * bba_pkg::MIN_BLOCK_BYTES);
      end else begin
        g.status = bba_pkg::ST_NOMEM;
      end
    end else begin
      blk = rq.byte_offset / bba_pkg::MIN_BLOCK_BYTES;
      if (blk >= bba_pkg::BLOCK_COUNT) begin
        g.status = bba_pkg::ST_BADADDR;
      end else begin
        // walk down to the first busy node on the path
        node = 0;
        span = bba_pkg::BLOCK_COUNT;
        lo = 0;
        walking = 1'b1;
        while (walking) begin
          if (tree[node] == bba_pkg::NODE_BUSY) begin
            tree[node] = bba_pkg::NODE_EMPTY;
            walking = 1'b0;
          end else if (span <= 1) begin
            walking = 1'b0;
          end else begin
            trail.push_back(node);
            span = span / 2;
            if (blk >= lo + span) begin
              node = 2 * node + 2;
              lo = lo + span;
            end else begin
              node = 2 * node + 1;
            end
          end
        end
        // merge empty buddies on the way back up
        for (j = trail.size() - 1; j >= 0; j--) begin
          node = trail[j];
          if (tree[2 * node + 1] == bba_pkg::NODE_EMPTY &&
              tree[2 * node + 2] == bba_pkg::NODE_EMPTY)
            tree[node] = bba_pkg::NODE_EMPTY;
        end
      end
    end
    return g;
  endfunction

  function automatic request_t make_request(input logic m, input logic [31:0] rb,
                                            input logic [31:0] ofs);
    request_t rq;
    rq.mode = m;
    rq.request_bytes = rb;
    rq.byte_offset = ofs;
    return rq;
  endfunction

  function automatic int idle_phase();
    if (accepted_count < 220) return 0;
    if (accepted_count < 440) return 1;
    return 2;
  endfunction

  // request driver: predicts on each accepted beat, then offers the next
  always @(posedge clk) begin
    int       pct;
    request_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        awaited_grants.push_back(allocator_outcome(make_request(
          in_ch.mode, in_ch.request_bytes, in_ch.byte_offset)));
        accepted_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        pct = (idle_phase() == 0) ? 19 : (idle_phase() == 1) ? 45 : 0;
        if (pending_requests.size() > 0 && $urandom_range(99) >= pct) begin
          nxt = pending_requests.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= nxt.mode;
          in_ch.request_bytes <= nxt.request_bytes;
          in_ch.byte_offset <= nxt.byte_offset;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stalls and one long hold-off
  always @(posedge clk) begin
    int     pct;
    grant_t exp_g;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_grants.size() == 0) begin
          $display("%0t: unexpected beat granted_offset=%h status=%0d", $time,
                   out_ch.granted_offset, out_ch.status);
          error_count++;
        end else begin
          exp_g = awaited_grants.pop_front();
          if (out_ch.granted_offset !== exp_g.granted_offset) begin
            $display("%0t: granted_offset expected %h actual %h", $time,
                     exp_g.granted_offset, out_ch.granted_offset);
            error_count++;
          end
          if (out_ch.status !== exp_g.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_g.status, out_ch.status);
            error_count++;
          end
        end
      end
      if (!hold_done && accepted_count >= 100) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        pct = (idle_phase() == 0) ? 45 : (idle_phase() == 1) ? 19 : 0;
        out_ch.ready <= ($urandom_range(99) >= pct);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("buddy_block_allocator_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int          n;
    logic [31:0] rb, ofs;
    error_count = 0;
    accepted_count = 0;
    quiet_cycles = 0;
    hold_left = 0;
    hold_done = 1'b0;
    for (int i = 0; i < NODE_COUNT; i++) tree[i] = bba_pkg::NODE_EMPTY;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = bba_pkg::MODE_ALLOC;
    in_ch.request_bytes = '0;
    in_ch.byte_offset = '0;
    out_ch.ready = 1'b0;

    // whole pool, a zero-byte request while full and a free inside it, then over-full and huge requests
    pending_requests.push_back(make_request(bba_pkg::MODE_ALLOC, POOL_BYTES, 32'hFFFF_FFFF));
    pending_requests.push_back(make_request(bba_pkg::MODE_ALLOC, 32'd0, '0));
    pending_requests.push_back(make_request(bba_pkg::MODE_FREE, 32'hFFFF_FFFF, 32'd5));
    pending_requests.push_back(make_request(bba_pkg::MODE_ALLOC, POOL_BYTES + 1, '0));
    pending_requests.push_back(make_request(bba_pkg::MODE_ALLOC, 32'hFFFF_FFFF, '0));
    // zero byte, one byte, exact and just-over minimum block, then two half-pool requests
    pending_requests.push_back(make_request(bba_pkg::MODE_ALLOC, 32'd0, '0));
    pending_requests.push_back(make_request(bba_pkg::MODE_ALLOC, 32'd1, '0));
    pending_requests.push_back(make_request(bba_pkg::MODE_ALLOC,
                                            bba_pkg::MIN_BLOCK_BYTES, '0));
    pending_requests.push_back(make_request(bba_pkg::MODE_ALLOC,
                                            bba_pkg::MIN_BLOCK_BYTES + 1, '0));
    pending_requests.push_back(make_request(bba_pkg::MODE_ALLOC, POOL_BYTES / 2, '0));
    pending_requests.push_back(make_request(bba_pkg::MODE_ALLOC, POOL_BYTES / 2, '0));
    // offsets out of the pool
    pending_requests.push_back(make_request(bba_pkg::MODE_FREE, '0, POOL_BYTES));
    pending_requests.push_back(make_request(bba_pkg::MODE_FREE, '0, 32'hFFFF_FFFF));
    // unaligned free, free of the last byte, double free, then more frees and a whole-pool request
    pending_requests.push_back(make_request(bba_pkg::MODE_FREE, '0, 32'd23));
    pending_requests.push_back(make_request(bba_pkg::MODE_FREE, '0, POOL_BYTES - 1));
    pending_requests.push_back(make_request(bba_pkg::MODE_FREE, '0, 32'd23));
    pending_requests.push_back(make_request(bba_pkg::MODE_FREE, '0, 32'd0));
    pending_requests.push_back(make_request(bba_pkg::MODE_FREE, '0, 32'd70));
    pending_requests.push_back(make_request(bba_pkg::MODE_FREE, '0, POOL_BYTES / 2));
    pending_requests.push_back(make_request(bba_pkg::MODE_ALLOC, POOL_BYTES, '0));
    pending_requests.push_back(make_request(bba_pkg::MODE_FREE, '0, 32'd0));

    // random allocate and free mix; most frees land inside the pool
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if ($urandom_range(99) < 55) begin
        case ($urandom_range(9))
          0:       rb = $urandom;
          1:       rb = $urandom_range(POOL_BYTES, 0);
          default: rb = $urandom_range(256, 0);
        endcase
        pending_requests.push_back(make_request(bba_pkg::MODE_ALLOC, rb, $urandom));
      end else begin
        ofs = ($urandom_range(99) < 85) ? $urandom_range(POOL_BYTES - 1, 0) : $urandom;
        pending_requests.push_back(make_request(bba_pkg::MODE_FREE, $urandom, ofs));
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_requests.size() == 0 && !in_ch.valid && awaited_grants.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && awaited_grants.size() == 0) begin
      $display("buddy_block_allocator_test: done, clean");
    end else begin
      $display("buddy_block_allocator_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
